// ===== sv/tbaf_pkg.sv =====
// ----------------------------------------------------------------------------
// tbaf_pkg : shared types and constants for the turbo autofire block
// Poll and result word layouts, slot settings and their decode.
// ----------------------------------------------------------------------------
package tbaf_pkg;

    localparam int CFG_REGS       = 4;
    localparam int PORT_COUNT     = 4;
    localparam int MIN_FRAMES     = 1;
    localparam int MAX_FRAMES     = 255;
    localparam int NATIVE_BUTTONS = 26;

    localparam int NATIVE_W   = 26;
    localparam int BUTTON_W   = 16;
    localparam int PORT_W     = 2;
    localparam int TRIGGER_W  = 5;
    localparam int FRAME_W    = 8;
    localparam int SLOT_REG_W = 40;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;

    // one poll from the input side
    typedef struct packed {
        logic                input_blocked;
        logic [3:0]          port_errors;
        logic [NATIVE_W-1:0] native_mask_p0;
        logic [NATIVE_W-1:0] native_mask_p1;
        logic [NATIVE_W-1:0] native_mask_p2;
        logic [NATIVE_W-1:0] native_mask_p3;
        logic [BUTTON_W-1:0] buttons_in_p0;
        logic [BUTTON_W-1:0] buttons_in_p1;
        logic [BUTTON_W-1:0] buttons_in_p2;
        logic [BUTTON_W-1:0] buttons_in_p3;
    } in_word_t;

    // one result word
    typedef struct packed {
        logic [BUTTON_W-1:0] buttons_out_p0;
        logic [BUTTON_W-1:0] buttons_out_p1;
        logic [BUTTON_W-1:0] buttons_out_p2;
        logic [BUTTON_W-1:0] buttons_out_p3;
        logic [3:0]          firing_slots;
    } out_word_t;

    // stored slot settings, frame counts already clamped
    typedef struct packed {
        logic [FRAME_W-1:0]   release_frames;
        logic [FRAME_W-1:0]   hold_frames;
        logic [BUTTON_W-1:0]  out_mask;
        logic [TRIGGER_W-1:0] trigger;
        logic [PORT_W-1:0]    port;
        logic                 enable;
    } slot_cfg_t;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic                fire;
        logic [PORT_W-1:0]   port;
        logic [BUTTON_W-1:0] out_mask;
    } lane_out_t;

    function automatic logic [FRAME_W-1:0] clamp_frames(input logic [FRAME_W-1:0] v);
        logic [FRAME_W-1:0] r;
        r = v;
        if (v < FRAME_W'(MIN_FRAMES))
            r = FRAME_W'(MIN_FRAMES);
        else if (v > FRAME_W'(MAX_FRAMES))
            r = FRAME_W'(MAX_FRAMES);
        return r;
    endfunction

    function automatic slot_cfg_t decode_slot(input logic [SLOT_REG_W-1:0] v);
        slot_cfg_t c;
        c.enable         = v[0];
        c.port           = (32'(v[2:1]) < PORT_COUNT) ? v[2:1] : '0;
        c.trigger        = v[7:3];
        c.out_mask       = v[23:8];
        c.hold_frames    = clamp_frames(v[31:24]);
        c.release_frames = clamp_frames(v[39:32]);
        return c;
    endfunction

    function automatic slot_cfg_t reset_slot();
        slot_cfg_t c;
        c                = '0;
        c.hold_frames    = clamp_frames('0);
        c.release_frames = clamp_frames('0);
        return c;
    endfunction

endpackage

// ===== sv/tbaf_lane.sv =====
// ----------------------------------------------------------------------------
// tbaf_lane : one autofire slot
// Holds the slot settings and its phase state, and steps once per poll.
// ----------------------------------------------------------------------------
module tbaf_lane (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr,
    input  tbaf_pkg::slot_cfg_t  cfg_wdata,
    input  logic                 step,
    input  tbaf_pkg::in_word_t   poll,
    output tbaf_pkg::slot_cfg_t  cfg,
    output tbaf_pkg::lane_out_t  result
);
    import tbaf_pkg::*;

    slot_cfg_t          cfg_reg;
    logic               firing_reg, firing_next;
    logic               seen_reg, seen_next;
    logic               await_reg, await_next;
    logic [FRAME_W-1:0] count_reg, count_next;

    logic [NATIVE_W-1:0] mask;
    logic [31:0]         mask_ext;
    logic                runnable;
    logic                port_err;
    logic                held;
    logic                fire;
    logic [FRAME_W-1:0]  count_inc;
    logic [FRAME_W-1:0]  phase_len;

    always_comb
    begin
        case (cfg_reg.port)
            2'd0:    mask = poll.native_mask_p0;
            2'd1:    mask = poll.native_mask_p1;
            2'd2:    mask = poll.native_mask_p2;
            2'd3:    mask = poll.native_mask_p3;
            default: mask = '0;
        endcase
    end

    // bits above the native width read as released
    assign mask_ext  = {{(32-NATIVE_W){1'b0}}, mask};
    assign held      = mask_ext[cfg_reg.trigger];
    assign port_err  = poll.port_errors[cfg_reg.port];
    assign runnable  = cfg_reg.enable && (cfg_reg.trigger < TRIGGER_W'(NATIVE_BUTTONS))
                       && (cfg_reg.out_mask != '0);
    assign count_inc = count_reg + FRAME_W'(1);
    assign phase_len = firing_reg ? cfg_reg.hold_frames : cfg_reg.release_frames;

    always_comb
    begin
        firing_next = firing_reg;
        seen_next   = seen_reg;
        await_next  = await_reg;
        count_next  = count_reg;
        fire        = 1'b0;
        if (!runnable || port_err)
        begin
            firing_next = 1'b0;
            seen_next   = 1'b0;
            await_next  = 1'b0;
            count_next  = '0;
        end
        else if (poll.input_blocked)
        begin
            firing_next = 1'b0;
            seen_next   = 1'b0;
            await_next  = 1'b1;
            count_next  = '0;
        end
        else if (await_reg && held)
        begin
            // still waiting for the trigger to let go
        end
        else if (!held)
        begin
            firing_next = 1'b0;
            seen_next   = 1'b0;
            await_next  = 1'b0;
            count_next  = '0;
        end
        else
        begin
            await_next = 1'b0;
            if (!seen_reg)
            begin
                firing_next = 1'b1;
                seen_next   = 1'b1;
                count_next  = '0;
            end
            else if (count_inc >= phase_len)
            begin
                firing_next = !firing_reg;
                count_next  = '0;
            end
            else
            begin
                count_next = count_inc;
            end
            fire = firing_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= reset_slot();
            firing_reg <= 1'b0;
            seen_reg   <= 1'b0;
            await_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            cfg_reg    <= cfg_wdata;
            firing_reg <= 1'b0;
            seen_reg   <= 1'b0;
            await_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            firing_reg <= firing_next;
            seen_reg   <= seen_next;
            await_reg  <= await_next;
            count_reg  <= count_next;
        end
    end

    assign cfg             = cfg_reg;
    assign result.fire     = fire;
    assign result.port     = cfg_reg.port;
    assign result.out_mask = cfg_reg.out_mask;

endmodule

// ===== sv/tbaf_merge.sv =====
// ----------------------------------------------------------------------------
// tbaf_merge : combines lane results into the output word
// ORs firing slot masks into their port words and collects fire flags.
// ----------------------------------------------------------------------------
module tbaf_merge #(
    parameter int LANE_COUNT = 4
) (
    input  tbaf_pkg::in_word_t   poll,
    input  tbaf_pkg::lane_out_t  lanes [LANE_COUNT],
    output tbaf_pkg::out_word_t  merged
);
    import tbaf_pkg::*;

    logic [BUTTON_W-1:0] words   [4];
    logic [BUTTON_W-1:0] fire_or [4];
    logic [3:0]          fire_bits;

    always_comb
    begin
        for (int p = 0; p < 4; p++)
            fire_or[p] = '0;
        fire_bits = '0;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            if (lanes[i].fire)
                fire_or[lanes[i].port] = fire_or[lanes[i].port] | lanes[i].out_mask;
            fire_bits[i] = lanes[i].fire;
        end
        words[0] = poll.buttons_in_p0 | fire_or[0];
        words[1] = poll.buttons_in_p1 | fire_or[1];
        words[2] = poll.buttons_in_p2 | fire_or[2];
        words[3] = poll.buttons_in_p3 | fire_or[3];
        for (int p = 0; p < 4; p++)
            if (p >= PORT_COUNT)
                words[p] = '0;
    end

    assign merged.buttons_out_p0 = words[0];
    assign merged.buttons_out_p1 = words[1];
    assign merged.buttons_out_p2 = words[2];
    assign merged.buttons_out_p3 = words[3];
    assign merged.firing_slots   = fire_bits;

endmodule

// ===== sv/turbo_button_autofire_top.sv =====
// ----------------------------------------------------------------------------
// turbo_button_autofire_top : per-poll turbo (autofire) macro block
// Slot lanes, merge stage, output register with skid, APB settings port.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one word per game input poll (blocked flag, pad error bits,
//                 native masks and mapped button words of four ports).
//   out channel : one word per poll, the button words with the masks of the
//                 slots in a press phase ORed in, plus the firing_slots flags.
//   APB port    : slot settings at byte offsets 0, 8, 16, 24 (64-bit data).
//                 Hold and release counts are clamped on write and a write
//                 restarts that slot. Write only while the block is idle.
// A poll taken while the output is free shows on out_valid in the next cycle.
// Throughput: one word per cycle while in_ready is high; every lane updates
//   its slot state in the same cycle the poll is taken, and the merge OR
//   tree feeds the output register directly.
// Stall: the output register plus a one-word skid let a poll be taken while a
//   result waits; in_ready drops only when both hold words.
// Reset: asynchronous, all slots disabled with hold and release of one frame,
//   slot state cleared, no word pending.
// ----------------------------------------------------------------------------
module turbo_button_autofire_top #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  tbaf_pkg::in_word_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output tbaf_pkg::out_word_t                   out_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tbaf_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [tbaf_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [tbaf_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import tbaf_pkg::*;

    // only the first CFG_REGS slots have a register; the rest never run
    localparam int LANE_COUNT = (SLOT_COUNT < CFG_REGS) ? SLOT_COUNT : CFG_REGS;

    logic       step;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    slot_cfg_t  cfg_wdata;
    slot_cfg_t  lane_cfg [LANE_COUNT];
    lane_out_t  lane_res [LANE_COUNT];
    out_word_t  merged;

    // output register and skid word
    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg,  out_data_next;
    logic      skid_valid_reg, skid_valid_next;
    out_word_t skid_data_reg,  skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign step      = in_valid && in_ready;

    // settings port: write lands on the access phase
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign reg_idx   = paddr[APB_ADDR_W-1:3];
    assign cfg_wdata = decode_slot(pwdata[SLOT_REG_W-1:0]);

    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < LANE_COUNT; i++)
            if (reg_idx == 2'(i))
                prdata = APB_DATA_W'(lane_cfg[i]);
    end

    // one lane per slot, all stepping on the same poll
    for (genvar g = 0; g < LANE_COUNT; g++)
    begin : g_lane
        tbaf_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg_wr    (cfg_wr && (reg_idx == 2'(g))),
            .cfg_wdata (cfg_wdata),
            .step      (step),
            .poll      (in_data),
            .cfg       (lane_cfg[g]),
            .result    (lane_res[g])
        );
    end

    tbaf_merge #(
        .LANE_COUNT (LANE_COUNT)
    ) u_merge (
        .poll   (in_data),
        .lanes  (lane_res),
        .merged (merged)
    );

    // output side: the skid word drains first, new words go straight to the
    // output register unless it is held by a stalled receiver
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = step;
                if (step)
                    out_data_next = merged;
            end
        end
        else if (step)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/tbaf_checker.sv =====
// ----------------------------------------------------------------------------
// tbaf_checker : port-level checks for the turbo autofire block
// Watches the channels of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
module tbaf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input tbaf_pkg::in_word_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input tbaf_pkg::out_word_t out_data
);
    import tbaf_pkg::*;

    logic fast_path;
    assign fast_path = in_valid && in_ready && (!out_valid || out_ready);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // input side only backs up once a result is waiting
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with no result pending");

    // with a free output, a poll shows next cycle and keeps its port 0 buttons
    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        fast_path |=> out_valid
            && ((out_data.buttons_out_p0 & $past(in_data.buttons_in_p0))
                == $past(in_data.buttons_in_p0)))
        else $error("poll not forwarded after one cycle");

    // a blocked poll fires no slot
    a_blocked_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fast_path && in_data.input_blocked |=> out_data.firing_slots == '0)
        else $error("slot fired on a blocked poll");

endmodule

bind turbo_button_autofire_top tbaf_checker u_tbaf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
